// File: design/ffb_pkg.sv
// Shared types and constants for the frame builder with byte-sum checksum.
// Used by ffb_front, ffb_queue, ffb_back and the top level.
package ffb_pkg;

  localparam int BYTE_W = 8;
  localparam int SUM_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEQUENCE  = 2'd0,
    REG_START     = 2'd1,
    REG_SEPARATOR = 2'd2,
    REG_END       = 2'd3
  } reg_index_t;

  localparam logic [BYTE_W-1:0] SEQUENCE_RESET  = 8'd32;
  localparam logic [BYTE_W-1:0] START_RESET     = 8'd2;
  localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd28;
  localparam logic [BYTE_W-1:0] END_RESET       = 8'd3;

  // Work that the back end expands into output bytes.
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_SEP_DATA = 2'd1,
    OP_DATA     = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  // Last step index of each op.
  localparam logic [STEP_W-1:0] START_LAST    = 3'd2;
  localparam logic [STEP_W-1:0] SEP_DATA_LAST = 3'd1;
  localparam logic [STEP_W-1:0] DATA_LAST     = 3'd0;
  localparam logic [STEP_W-1:0] FINISH_LAST   = 3'd4;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [SUM_W-1:0]  sum;
    logic              flag;
  } cmd_t;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_A    = 8'h61;

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = ASCII_ZERO + {4'd0, nib};
    end else begin
      r = ASCII_A + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

// File: design/fiscal_frame_builder_sum_checksum_unit.sv
// Top level of the STX/ETX frame builder with hex byte-sum checksum.
// Instantiates ffb_front, ffb_queue and ffb_back; uses ffb_pkg.
//
// Each input transaction is taken by the front end, which updates the frame state
// and the running sum and queues a command for each item that yields output bytes.
// The back end emits one frame byte per cycle into the output register while
// the receiver keeps popping: a start item gives 3 bytes, the first payload byte 2,
// later payload bytes 1, and a finish item 5 (end marker plus four lowercase hex
// digits, last set on the final one). Items that produce no bytes are not queued.
// Sustained rate is set by the one-byte-per-cycle output register and by pop; push
// stalls (full) only when the QUEUE_DEPTH-entry command queue is full.
// Configuration writes are always ready and apply on the next cycle.
module fiscal_frame_builder_sum_checksum_unit #(
  parameter int MAX_PAYLOAD = 240,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func,
  input  logic [ffb_pkg::BYTE_W-1:0]      value,
  output logic                            empty,
  input  logic                            pop,
  output logic [ffb_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last,
  output logic                            too_long,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ffb_pkg::BYTE_W-1:0]      cfg_data
);

  logic          enq;
  ffb_pkg::cmd_t enq_cmd;
  ffb_pkg::cmd_t head_cmd;
  logic          cmd_empty;
  logic          cmd_pop;

  ffb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .enq       (enq),
    .enq_cmd   (enq_cmd)
  );

  ffb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (enq_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (head_cmd),
    .empty   (cmd_empty)
  );

  ffb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_byte  (out_byte),
    .last      (last),
    .too_long  (too_long),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: design/ffb_front.sv
// Front end: configuration registers, item classification and frame state.
// Depends on ffb_pkg; produces ffb_pkg::cmd_t transactions for the queue.
module ffb_front #(
  parameter int MAX_PAYLOAD = 240
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic [1:0]                          func,
  input  logic [ffb_pkg::BYTE_W-1:0]          value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ffb_pkg::BYTE_W-1:0]          cfg_data,
  output logic                                enq,
  output ffb_pkg::cmd_t                       enq_cmd
);

  localparam logic [ffb_pkg::BYTE_W-1:0] MAX_CNT = MAX_PAYLOAD[ffb_pkg::BYTE_W-1:0];

  logic [ffb_pkg::BYTE_W-1:0] sequence_byte;
  logic [ffb_pkg::BYTE_W-1:0] start_marker;
  logic [ffb_pkg::BYTE_W-1:0] separator_marker;
  logic [ffb_pkg::BYTE_W-1:0] end_marker;

  logic [ffb_pkg::SUM_W-1:0]  running_sum, running_sum_next;
  logic [ffb_pkg::BYTE_W-1:0] payload_count, payload_count_next;
  logic                       overflowed, overflowed_next;
  logic                       in_frame, in_frame_next;
  logic                       accept;
  logic                       first;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;
  assign first = (payload_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_byte    <= ffb_pkg::SEQUENCE_RESET;
      start_marker     <= ffb_pkg::START_RESET;
      separator_marker <= ffb_pkg::SEPARATOR_RESET;
      end_marker       <= ffb_pkg::END_RESET;
    end else if (cfg_valid) begin
      case (ffb_pkg::reg_index_t'(cfg_index))
        ffb_pkg::REG_SEQUENCE:  sequence_byte    <= cfg_data;
        ffb_pkg::REG_START:     start_marker     <= cfg_data;
        ffb_pkg::REG_SEPARATOR: separator_marker <= cfg_data;
        ffb_pkg::REG_END:       end_marker       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    running_sum_next   = running_sum;
    payload_count_next = payload_count;
    overflowed_next    = overflowed;
    in_frame_next      = in_frame;
    enq                = 1'b0;
    enq_cmd.op         = ffb_pkg::OP_DATA;
    enq_cmd.b0         = value;
    enq_cmd.b1         = value;
    enq_cmd.b2         = value;
    enq_cmd.sum        = running_sum;
    enq_cmd.flag       = 1'b0;
    if (accept) begin
      case (ffb_pkg::func_t'(func))
        ffb_pkg::FUNC_START: begin
          enq                = 1'b1;
          enq_cmd.op         = ffb_pkg::OP_START;
          enq_cmd.b0         = start_marker;
          enq_cmd.b1         = sequence_byte;
          running_sum_next   = {8'd0, start_marker} + {8'd0, sequence_byte}
                               + {8'd0, value};
          payload_count_next = '0;
          overflowed_next    = 1'b0;
          in_frame_next      = 1'b1;
        end
        ffb_pkg::FUNC_DATA: begin
          if (in_frame) begin
            if (payload_count >= MAX_CNT) begin
              overflowed_next = 1'b1;
            end else begin
              enq                = 1'b1;
              enq_cmd.op         = first ? ffb_pkg::OP_SEP_DATA : ffb_pkg::OP_DATA;
              enq_cmd.b0         = first ? separator_marker : value;
              running_sum_next   = running_sum
                                   + {8'd0, (first ? separator_marker : 8'd0)}
                                   + {8'd0, value};
              payload_count_next = payload_count + 8'd1;
            end
          end
        end
        ffb_pkg::FUNC_FINISH: begin
          if (in_frame) begin
            enq                = 1'b1;
            enq_cmd.op         = ffb_pkg::OP_FINISH;
            enq_cmd.b0         = end_marker;
            enq_cmd.sum        = running_sum + {8'd0, end_marker};
            enq_cmd.flag       = overflowed;
            running_sum_next   = '0;
            payload_count_next = '0;
            overflowed_next    = 1'b0;
            in_frame_next      = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      payload_count <= '0;
      overflowed    <= 1'b0;
      in_frame      <= 1'b0;
    end else begin
      running_sum   <= running_sum_next;
      payload_count <= payload_count_next;
      overflowed    <= overflowed_next;
      in_frame      <= in_frame_next;
    end
  end

endmodule

// File: design/ffb_queue.sv
// Short command queue between front and back end.
// Depends on ffb_pkg for the cmd_t transaction type.
module ffb_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ffb_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output ffb_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ffb_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: design/ffb_back.sv
// Back end: expands each command into frame bytes, one per cycle into an output
// register while it is empty or popped. Depends on ffb_pkg.
module ffb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ffb_pkg::cmd_t              cmd,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  output logic [ffb_pkg::BYTE_W-1:0] out_byte,
  output logic                       last,
  output logic                       too_long,
  output logic                       empty,
  input  logic                       pop
);

  logic [ffb_pkg::STEP_W-1:0] step;
  logic [ffb_pkg::STEP_W-1:0] last_step;
  logic                       out_valid;
  logic                       load;
  logic [ffb_pkg::BYTE_W-1:0] byte_sel;
  logic [3:0]                 nib;

  assign empty = !out_valid;
  assign load = !cmd_empty && (!out_valid || pop);
  assign cmd_pop = load && (step == last_step);

  always_comb begin
    case (cmd.op)
      ffb_pkg::OP_START:    last_step = ffb_pkg::START_LAST;
      ffb_pkg::OP_SEP_DATA: last_step = ffb_pkg::SEP_DATA_LAST;
      ffb_pkg::OP_DATA:     last_step = ffb_pkg::DATA_LAST;
      ffb_pkg::OP_FINISH:   last_step = ffb_pkg::FINISH_LAST;
      default:              last_step = ffb_pkg::DATA_LAST;
    endcase
  end

  always_comb begin
    case (step)
      3'd1:    nib = cmd.sum[15:12];
      3'd2:    nib = cmd.sum[11:8];
      3'd3:    nib = cmd.sum[7:4];
      default: nib = cmd.sum[3:0];
    endcase
  end

  always_comb begin
    if (cmd.op == ffb_pkg::OP_FINISH && step != '0) begin
      byte_sel = ffb_pkg::hex_char(nib);
    end else begin
      case (step)
        3'd0:    byte_sel = cmd.b0;
        3'd1:    byte_sel = cmd.b1;
        default: byte_sel = cmd.b2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_sel;
      last     <= (cmd.op == ffb_pkg::OP_FINISH) && (step == last_step);
      too_long <= (cmd.op == ffb_pkg::OP_FINISH) && cmd.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= (step == last_step) ? '0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sim/fiscal_frame_builder_sum_checksum_unit_test.sv
// Testbench for fiscal_frame_builder_sum_checksum_unit: predicts each frame byte, last and
// too_long flag and checks the popped output stream against it. Depends on ffb_pkg and the RTL.
module fiscal_frame_builder_sum_checksum_unit_test;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 10;
  localparam int PAYLOAD_LIMIT  = 240;
  localparam int MAX_GAP        = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_WAIT       = 5000;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int RANDOM_ITEMS   = 40;
  localparam int HEX_DIGITS     = 4;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_A    = 8'h61;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       too_long;
  } frame_byte_t;

  logic                some_unused_guard;
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  ffb_pkg::func_t      func = ffb_pkg::FUNC_NONE;
  logic [7:0]          value = 8'h00;
  logic                pop = 1'b0;
  logic                cfg_valid = 1'b0;
  ffb_pkg::reg_index_t cfg_index = ffb_pkg::REG_SEQUENCE;
  logic [7:0]          cfg_data = 8'h00;
  logic                full;
  logic                empty;
  logic [7:0]          out_byte;
  logic                last;
  logic                too_long;
  logic                cfg_ready;

  assign some_unused_guard = 1'b0;

  fiscal_frame_builder_sum_checksum_unit #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .value(value),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last(last),
    .too_long(too_long),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Frame state and marker registers as the block should hold them.
  logic [7:0]  seq_byte  = ffb_pkg::SEQUENCE_RESET;
  logic [7:0]  stx_byte  = ffb_pkg::START_RESET;
  logic [7:0]  fs_byte   = ffb_pkg::SEPARATOR_RESET;
  logic [7:0]  etx_byte  = ffb_pkg::END_RESET;
  logic [15:0] frame_sum = '0;
  logic [7:0]  payload_cnt = '0;
  logic        dropped = 1'b0;
  logic        frame_open = 1'b0;

  frame_byte_t expected_bytes[$];

  bit sender_gaps_on = 1'b1;
  bit receiver_gaps_on = 1'b1;
  int hold_wanted = 0;
  int hold_done = 0;
  int fail_count = 0;
  int items_used = 0;
  int bytes_checked = 0;
  int cfg_writes = 0;
  int frames_closed = 0;
  int frames_flagged = 0;

  function automatic void emit_summed(input logic [7:0] b, input logic flag);
    expected_bytes.push_back('{b, 1'b0, flag});
    frame_sum = frame_sum + {8'd0, b};
  endfunction

  function automatic void predict_frame(input ffb_pkg::func_t f, input logic [7:0] v);
    logic [3:0] nib;
    case (f)
      ffb_pkg::FUNC_START: begin
        frame_sum = '0;
        payload_cnt = '0;
        dropped = 1'b0;
        frame_open = 1'b1;
        emit_summed(stx_byte, 1'b0);
        emit_summed(seq_byte, 1'b0);
        emit_summed(v, 1'b0);
      end
      ffb_pkg::FUNC_DATA: begin
        if (frame_open) begin
          if (payload_cnt >= PAYLOAD_LIMIT) begin
            dropped = 1'b1;
          end else begin
            if (payload_cnt == 0) emit_summed(fs_byte, 1'b0);
            emit_summed(v, 1'b0);
            payload_cnt = payload_cnt + 8'd1;
          end
        end
      end
      ffb_pkg::FUNC_FINISH: begin
        if (frame_open) begin
          emit_summed(etx_byte, dropped);
          for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
            nib = frame_sum[i*4 +: 4];
            expected_bytes.push_back('{(nib < 4'd10) ? DIGIT_ZERO + {4'd0, nib}
                                                     : DIGIT_A + {4'd0, nib - 4'd10},
                                       (i == 0), dropped});
          end
          frames_closed++;
          if (dropped) frames_flagged++;
          frame_sum = '0;
          payload_cnt = '0;
          dropped = 1'b0;
          frame_open = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge that took the item, push still high.
  task automatic send_item(input ffb_pkg::func_t f, input logic [7:0] v);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    if (f == ffb_pkg::FUNC_START || (frame_open && f != ffb_pkg::FUNC_NONE)) items_used++;
    predict_frame(f, v);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int n_payload);
    send_item(ffb_pkg::FUNC_START, cmd);
    for (int i = 0; i < n_payload; i++) send_item(ffb_pkg::FUNC_DATA, 8'($urandom));
    send_item(ffb_pkg::FUNC_FINISH, 8'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ffb_pkg::reg_index_t idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ffb_pkg::REG_SEQUENCE:  seq_byte = d;
      ffb_pkg::REG_START:     stx_byte = d;
      ffb_pkg::REG_SEPARATOR: fs_byte = d;
      ffb_pkg::REG_END:       etx_byte = d;
      default: begin
      end
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] seq, input logic [7:0] stx,
                             input logic [7:0] fs, input logic [7:0] etx);
    wait_idle();
    write_reg(ffb_pkg::REG_SEQUENCE, seq);
    write_reg(ffb_pkg::REG_START, stx);
    write_reg(ffb_pkg::REG_SEPARATOR, fs);
    write_reg(ffb_pkg::REG_END, etx);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // Default markers; stray items around frames, empty payload, abandoned frame.
  task automatic test_directed_frames();
    send_item(ffb_pkg::FUNC_DATA, 8'h55);
    send_item(ffb_pkg::FUNC_FINISH, 8'hAA);
    send_item(ffb_pkg::FUNC_NONE, 8'hFF);
    send_item(ffb_pkg::FUNC_START, 8'h00);
    send_item(ffb_pkg::FUNC_DATA, 8'hFF);
    send_item(ffb_pkg::FUNC_DATA, 8'h00);
    send_item(ffb_pkg::FUNC_NONE, 8'h5A);
    send_item(ffb_pkg::FUNC_FINISH, 8'hFF);
    send_item(ffb_pkg::FUNC_START, 8'hFF);
    send_item(ffb_pkg::FUNC_FINISH, 8'h00);
    send_item(ffb_pkg::FUNC_START, 8'h81);
    send_item(ffb_pkg::FUNC_DATA, 8'h7E);
    send_item(ffb_pkg::FUNC_START, 8'h42);
    send_item(ffb_pkg::FUNC_DATA, 8'hC3);
    send_item(ffb_pkg::FUNC_FINISH, 8'($urandom));
    send_item(ffb_pkg::FUNC_FINISH, 8'h0F);
    send_item(ffb_pkg::FUNC_DATA, 8'hF0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_markers(8'h00, 8'h00, 8'h00, 8'h00);
    send_item(ffb_pkg::FUNC_START, 8'h00);
    send_item(ffb_pkg::FUNC_DATA, 8'h00);
    send_item(ffb_pkg::FUNC_FINISH, 8'h00);
    set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(ffb_pkg::FUNC_START, 8'hFF);
    for (int i = 0; i < 3; i++) send_item(ffb_pkg::FUNC_DATA, 8'hFF);
    send_item(ffb_pkg::FUNC_FINISH, 8'hFF);
    set_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_frame(8'($urandom), 2);
    wait_idle();
  endtask

  // Payload runs two bytes past the limit; the extra bytes are dropped and flagged.
  task automatic test_long_payload();
    send_frame(8'($urandom), PAYLOAD_LIMIT + 2);
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    hold_wanted++;
    for (int i = 0; i < 3; i++) send_frame(8'($urandom), 4);
    wait_idle();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int n_payload;
    int start_count;
    start_count = items_used;
    while (items_used - start_count < RANDOM_ITEMS) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      receiver_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        set_markers(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
      if ($urandom_range(0, 99) < 80) begin
        send_item(ffb_pkg::FUNC_START, 8'($urandom));
        n_payload = $urandom_range(0, 12);
        for (int i = 0; i < n_payload; i++) begin
          if ($urandom_range(0, 19) == 0) send_item(ffb_pkg::FUNC_NONE, 8'($urandom));
          else send_item(ffb_pkg::FUNC_DATA, 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send_item(ffb_pkg::FUNC_FINISH, 8'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(ffb_pkg::FUNC_DATA, 8'($urandom));
          1:       send_item(ffb_pkg::FUNC_FINISH, 8'($urandom));
          default: send_item(ffb_pkg::FUNC_NONE, 8'($urandom));
        endcase
      end
    end
    send_item(ffb_pkg::FUNC_FINISH, 8'($urandom));
    receiver_gaps_on = 1'b1;
  endtask

  initial begin : result_checker
    int stall;
    frame_byte_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = receiver_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_wanted != hold_done) begin
        stall = HOLD_CYCLES;
        hold_done++;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: out_byte=%0h last=%0b too_long=%0b",
               out_byte, last, too_long);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          fail_count++;
        end
        if (too_long !== want.too_long) begin
          $error("too_long: expected %0b, actual %0b", want.too_long, too_long);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : test_sequence
    int waited;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_register_extremes();
    test_long_payload();
    test_backpressure();
    test_random_frames();
    push <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d frame bytes never arrived", expected_bytes.size());
      fail_count++;
    end
    $display("Covered %0d frame items, %0d frames closed (%0d over the limit), %0d reg writes.",
             items_used, frames_closed, frames_flagged, cfg_writes);
    $display("Compared %0d output bytes; output held off %0d time(s) to fill the block.",
             bytes_checked, hold_done);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ffb_pkg.sv
design/ffb_front.sv
design/ffb_queue.sv
design/ffb_back.sv
design/fiscal_frame_builder_sum_checksum_unit.sv
sim/fiscal_frame_builder_sum_checksum_unit_test.sv
